@@ hw/rtl/imd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types for the integer matrix determinant block.
// ----------------------------------------------------------------------------
package imd_pkg;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,      // write element into store
		OP_RD_PIV,    // issue read of column-k entry (row scan)
		OP_TZ,        // compare trailing zeros of read data
		OP_RD_A,      // capture read data in register A (pivot row entry in a swap)
		OP_RD_B,      // read other row entry
		OP_SWAP_A,    // write register A to other row
		OP_SWAP_B,    // write register B to pivot row
		OP_INV,       // inverse step
		OP_DET,       // det *= pivot
		OP_FACT,      // factor = (w[r][k] >> v) * inv
		OP_MUL,       // prod = f * w[k][c]
		OP_SUB,       // write w[r][c] - prod
		OP_NEG,       // det = -det
		OP_CLR        // det = 1
	} imd_op_t;

	typedef struct packed {
		imd_op_t    op;
		logic [3:0] row;
		logic [3:0] col;
		logic [2:0] inv_step;
	} imd_cmd_t;

	typedef struct packed {
		logic       rd_zero;   // last read data is zero
		logic [5:0] best_tz;   // smallest trailing zero count found
		logic [3:0] best_row;
	} imd_sts_t;

endpackage

@@ hw/rtl/imd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imd_datapath
// Matrix store, one 32x32 multiplier, pivot search and determinant register.
// ----------------------------------------------------------------------------
module imd_datapath #(
	parameter int MAX_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imd_pkg::imd_cmd_t  cmd,
	input  logic [31:0]        element,
	output imd_pkg::imd_sts_t  sts,
	output logic [31:0]        det
);
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = $clog2(DEPTH);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q, a_q, b_q, inv_q, pv_q, f_q, prod_q, det_q;
	logic [5:0]  best_tz_q, tz;
	logic [3:0]  best_row_q;
	logic [AW-1:0] addr;
	logic [31:0] mul_a, mul_b, mul_y;
	logic [63:0] mul_full;
	logic        we;
	logic [31:0] wdata;

	// row r, column c held at r*MAX_SIZE+c
	assign addr = AW'(int'(cmd.row) * MAX_SIZE + int'(cmd.col));

	always_comb begin
		tz = 6'd32;
		for (int i = 31; i >= 0; i--) begin
			if (rd_q[i]) tz = 6'(i);
		end
	end

	always_comb begin
		mul_a = det_q;
		mul_b = rd_q;
		case (cmd.op)
			imd_pkg::OP_INV: begin
				mul_a = inv_q;
				mul_b = cmd.inv_step[0] ? 32'd2 - prod_q : pv_q;
			end
			imd_pkg::OP_FACT: begin
				mul_a = rd_q >> best_tz_q[4:0];
				mul_b = inv_q;
			end
			imd_pkg::OP_MUL: begin
				mul_a = f_q;
				mul_b = rd_q;
			end
			default: ;
		endcase
	end
	assign mul_full = 64'(mul_a) * 64'(mul_b);
	assign mul_y    = mul_full[31:0];

	always_comb begin
		we    = 1'b0;
		wdata = element;
		case (cmd.op)
			imd_pkg::OP_LOAD:   we = 1'b1;
			imd_pkg::OP_SWAP_A: begin we = 1'b1; wdata = a_q; end
			imd_pkg::OP_SWAP_B: begin we = 1'b1; wdata = b_q; end
			imd_pkg::OP_SUB:    begin we = 1'b1; wdata = a_q - prod_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q      <= 32'd1;
			best_tz_q  <= 6'd33;
			best_row_q <= '0;
		end else begin
			case (cmd.op)
				imd_pkg::OP_CLR: begin
					det_q     <= 32'd1;
					best_tz_q <= 6'd33;
				end
				imd_pkg::OP_TZ: begin
					if (tz < best_tz_q) begin
						best_tz_q  <= tz;
						best_row_q <= cmd.row;
					end
				end
				imd_pkg::OP_NEG: det_q <= 32'd0 - det_q;
				imd_pkg::OP_DET: begin
					det_q     <= mul_y;
					best_tz_q <= best_tz_q;
				end
				imd_pkg::OP_RD_PIV: if (cmd.row == cmd.col) best_tz_q <= 6'd33;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			imd_pkg::OP_RD_A: a_q <= rd_q;
			imd_pkg::OP_RD_B: b_q <= rd_q;
			imd_pkg::OP_DET: begin
				pv_q  <= rd_q >> best_tz_q[4:0];
				inv_q <= rd_q >> best_tz_q[4:0];
			end
			imd_pkg::OP_INV: begin
				if (cmd.inv_step[0]) inv_q <= mul_y;
				else prod_q <= mul_y;
			end
			imd_pkg::OP_FACT: f_q <= mul_y;
			imd_pkg::OP_MUL: prod_q <= mul_y;
			default: ;
		endcase
	end

	assign sts.rd_zero  = (rd_q == 32'd0);
	assign sts.best_tz  = best_tz_q;
	assign sts.best_row = best_row_q;
	assign det          = det_q;
endmodule

@@ hw/rtl/imd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imd_ctrl
// Sequencer: loading, pivot search, row swap and elimination.
// ----------------------------------------------------------------------------
module imd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         n,
	input  logic               cfg_hit,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  imd_pkg::imd_sts_t  sts,
	input  logic [31:0]        det,
	output logic [31:0]        determinant,
	output imd_pkg::imd_cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_LOAD, S_INIT, S_PRD, S_PTZ, S_PCHK, S_SWRA, S_SWRB, S_SWWA, S_SWWB,
		S_SWNX, S_DRD, S_DWAIT, S_DET, S_INV, S_RRD, S_RCHK, S_FRD, S_FACT,
		S_CRK, S_CRR, S_CMUL, S_CSUB, S_NEXT, S_OUT
	} state_t;

	state_t      state_q;
	logic [3:0]  k_q, r_q, c_q, lr_q, lc_q;
	logic [2:0]  it_q;
	logic [3:0]  last;
	logic        res_v_q;
	logic [31:0] res_q;

	assign last      = 4'(n - 5'd1);
	assign in_ready  = (state_q == S_LOAD) && !res_v_q;
	assign out_valid = res_v_q;
	assign determinant = res_q;

	always_comb begin
		cmd = '{op: imd_pkg::OP_NONE, row: r_q, col: c_q, inv_step: it_q};
		case (state_q)
			S_LOAD: begin
				cmd.op = in_valid && in_ready ? imd_pkg::OP_LOAD : imd_pkg::OP_NONE;
				cmd.row = lr_q; cmd.col = lc_q;
			end
			S_INIT: cmd.op = imd_pkg::OP_CLR;
			S_PRD:  begin cmd.op = imd_pkg::OP_RD_PIV; cmd.col = k_q; end
			S_PTZ:  begin cmd.op = imd_pkg::OP_TZ; cmd.col = k_q; end
			S_SWRA: begin
				cmd.row = k_q;
				// a row swap flips the sign once
				if (c_q == '0) cmd.op = imd_pkg::OP_NEG;
			end
			S_SWRB: begin cmd.op = imd_pkg::OP_RD_A; cmd.row = sts.best_row; end
			S_SWWA: begin cmd.op = imd_pkg::OP_RD_B; cmd.row = sts.best_row; end
			S_SWWB: begin cmd.op = imd_pkg::OP_SWAP_A; cmd.row = sts.best_row; end
			S_SWNX: begin cmd.op = imd_pkg::OP_SWAP_B; cmd.row = k_q; end
			S_DRD, S_DWAIT: begin cmd.row = k_q; cmd.col = k_q; end
			S_DET:  begin cmd.op = imd_pkg::OP_DET; cmd.row = k_q; cmd.col = k_q; end
			S_INV:  cmd.op = imd_pkg::OP_INV;
			S_RRD, S_RCHK: cmd.col = k_q;
			S_FACT: begin cmd.op = imd_pkg::OP_FACT; cmd.col = k_q; end
			S_CRK:  begin cmd.op = imd_pkg::OP_NONE; cmd.row = k_q; end
			S_CRR:  cmd.op = imd_pkg::OP_MUL;
			S_CMUL: cmd.op = imd_pkg::OP_RD_A;
			S_CSUB: cmd.op = imd_pkg::OP_SUB;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q <= '0; r_q <= '0; c_q <= '0; lr_q <= '0; lc_q <= '0; it_q <= '0;
			res_v_q <= 1'b0;
			res_q   <= '0;
		end else begin
			if (res_v_q && out_ready) res_v_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (cfg_hit) begin
						lr_q <= '0; lc_q <= '0;
					end else if (in_valid && in_ready) begin
						if (lc_q == last) begin
							lc_q <= '0;
							if (lr_q == last) begin
								lr_q <= '0; k_q <= '0; state_q <= S_INIT;
							end else lr_q <= lr_q + 4'd1;
						end else lc_q <= lc_q + 4'd1;
					end
				end
				S_INIT: begin r_q <= k_q; state_q <= S_PRD; end
				S_PRD:  state_q <= S_PTZ;
				S_PTZ: begin
					if (r_q == last) state_q <= S_PCHK;
					else begin r_q <= r_q + 4'd1; state_q <= S_PRD; end
				end
				S_PCHK: begin
					c_q <= '0;
					if (sts.best_tz > 6'd31) begin
						res_q <= '0; state_q <= S_OUT;
					end else if (sts.best_row != k_q) state_q <= S_SWRA;
					else state_q <= S_DRD;
				end
				S_SWRA: state_q <= S_SWRB;
				S_SWRB: state_q <= S_SWWA;
				S_SWWA: state_q <= S_SWWB;
				S_SWWB: state_q <= S_SWNX;
				S_SWNX: begin
					if (c_q == last) state_q <= S_DRD;
					else begin c_q <= c_q + 4'd1; state_q <= S_SWRA; end
				end
				S_DRD: state_q <= S_DWAIT;
				S_DWAIT: state_q <= S_DET;
				S_DET: begin
					it_q <= '0;
					state_q <= S_INV;
				end
				S_INV: begin
					if (it_q == 3'd7) begin
						state_q <= (k_q == last) ? S_NEXT : S_RRD;
						r_q <= k_q + 4'd1;
					end
					it_q <= it_q + 3'd1;
				end
				S_RRD:  state_q <= S_RCHK;
				S_RCHK: begin
					if (sts.rd_zero) state_q <= (r_q == last) ? S_NEXT : S_RRD;
					else state_q <= S_FACT;
					if (sts.rd_zero) r_q <= r_q + 4'd1;
				end
				S_FACT: begin c_q <= k_q; state_q <= S_CRK; end
				S_CRK:  state_q <= S_CRR;
				S_CRR:  state_q <= S_CMUL;
				S_CMUL: state_q <= S_CSUB;
				S_CSUB: begin
					if (c_q == last) begin
						state_q <= (r_q == last) ? S_NEXT : S_RRD;
						r_q <= r_q + 4'd1;
					end else begin
						c_q <= c_q + 4'd1; state_q <= S_CRK;
					end
				end
				S_NEXT: begin
					if (k_q == last) begin
						res_q <= det; state_q <= S_OUT;
					end else begin
						k_q <= k_q + 4'd1; r_q <= k_q + 4'd1; state_q <= S_PRD;
					end
				end
				S_OUT: if (!res_v_q) begin
					res_v_q <= 1'b1; state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

@@ hw/rtl/integer_matrix_determinant.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_determinant
// Determinant modulo 2^32 of a square signed matrix, by elimination with
// 2-adic pivoting and an odd-part inverse.
// ----------------------------------------------------------------------------
//  channel   signals                          beat
//  cfg       cfg_valid/cfg_ready, cfg_data    matrix side length
//  in        in_valid/in_ready, element       one entry, row-major
//  out       out_valid/out_ready, determinant one per matrix
//
//  One entry a cycle while loading and no result is waiting. After the last
//  entry the sequencer eliminates each row column by column (pivot-row read,
//  multiply, row read, subtract write), searches the pivot row by row and
//  swaps column by column, all via the single memory port and multiplier.
//  Reset clears the counters; store contents are not cleared.
//  The next load starts once the result has been taken.
// ----------------------------------------------------------------------------
module integer_matrix_determinant #(
	parameter int MAX_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] element,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] determinant
);
	imd_pkg::imd_cmd_t cmd;
	imd_pkg::imd_sts_t sts;
	logic [31:0] det;
	logic [4:0]  n_q;
	logic        cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid;

	// size register, clamped to 2..MAX_SIZE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 5'(MAX_SIZE);
		end else if (cfg_hit) begin
			if (cfg_data < 5'd2) n_q <= 5'd2;
			else if (cfg_data > 5'(MAX_SIZE)) n_q <= 5'(MAX_SIZE);
			else n_q <= cfg_data;
		end
	end

	imd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .n(n_q), .cfg_hit(cfg_hit),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .det(det), .determinant(determinant), .cmd(cmd)
	);

	imd_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .element(element),
		.sts(sts), .det(det)
	);
endmodule
